// File: rtl/nfcd_pkg.sv
// ----------------------------------------------------------------------------
// nfcd_pkg
// Types and constants shared by the frame deframer modules: parser phases,
// status codes, the parser state record and the result record.
// ----------------------------------------------------------------------------
package nfcd_pkg;

	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] START_CODE  = 8'hFF;
	localparam logic [8:0] FRAME_EXTRA = 9'd7;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_PRE  = 3'd1,
		PH_LEN  = 3'd2,
		PH_LCS  = 3'd3,
		PH_DATA = 3'd4,
		PH_DCS  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_START   = 3'd1,
		ST_EXHAUST = 3'd2,
		ST_LCS     = 3'd3,
		ST_DCS     = 3'd4
	} status_t;

	typedef struct packed {
		phase_t     phase;
		logic [8:0] bytes_left;
		logic [7:0] payload_left;
		logic [7:0] length_seen;
		logic [7:0] running_sum;
	} parse_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		status_t    status;
		logic [7:0] frame_length;
		logic       last;
	} result_t;

endpackage

// File: rtl/nfcd_parser.sv
// ----------------------------------------------------------------------------
// nfcd_parser
// Next-state and result logic of the deframer for one received byte.
// Purely combinational; the caller holds the state register.
// ----------------------------------------------------------------------------
module nfcd_parser #(
	parameter int MAX_FRAME_LEN = 255
) (
	input  nfcd_pkg::parse_state_t state,
	input  logic [7:0]             rx_byte,
	input  logic                   start_req,
	input  logic [7:0]             window_len,
	output nfcd_pkg::parse_state_t next_state,
	output logic                   res_valid,
	output nfcd_pkg::result_t      res
);
	import nfcd_pkg::*;

	localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

	parse_state_t cur;
	logic [7:0]   wl;
	logic         fin;
	logic [7:0]   len_sum;
	logic [7:0]   data_sum;

	always_comb begin
		wl = (window_len > MaxLen) ? MaxLen : window_len;

		cur = state;
		if (start_req) begin
			cur.phase        = PH_PRE;
			cur.bytes_left   = {1'b0, wl} + FRAME_EXTRA;
			cur.payload_left = '0;
			cur.length_seen  = '0;
			cur.running_sum  = '0;
		end

		fin      = (cur.bytes_left <= 9'd1);
		len_sum  = cur.length_seen + rx_byte;
		data_sum = cur.running_sum + rx_byte;

		next_state = cur;
		res_valid  = 1'b0;
		res        = '{kind: 1'b1, data_byte: 8'h00, status: ST_OK,
		               frame_length: 8'h00, last: 1'b1};

		if (cur.phase != PH_IDLE) begin
			if (cur.bytes_left != 9'd0)
				next_state.bytes_left = cur.bytes_left - 9'd1;

			case (cur.phase)
				PH_PRE: begin
					if (rx_byte == BYTE_ZERO) begin
						res_valid  = fin;
						res.status = ST_START;
					end else if (rx_byte != START_CODE) begin
						res_valid  = 1'b1;
						res.status = ST_START;
					end else begin
						next_state.phase = PH_LEN;
						res_valid        = fin;
						res.status       = ST_EXHAUST;
					end
				end
				PH_LEN: begin
					next_state.length_seen = rx_byte;
					next_state.phase       = PH_LCS;
					res_valid              = fin;
					res.status             = ST_EXHAUST;
				end
				PH_LCS: begin
					if (len_sum != 8'h00) begin
						res_valid  = 1'b1;
						res.status = ST_LCS;
					end else begin
						next_state.running_sum  = '0;
						next_state.payload_left = cur.length_seen;
						next_state.phase = (cur.length_seen != 8'h00) ? PH_DATA : PH_DCS;
						res_valid  = fin;
						res.status = ST_EXHAUST;
					end
				end
				PH_DATA: begin
					next_state.running_sum  = data_sum;
					next_state.payload_left = cur.payload_left - 8'd1;
					if (cur.payload_left == 8'd1)
						next_state.phase = PH_DCS;
					res_valid = 1'b1;
					if (fin) begin
						res.status = ST_EXHAUST;
					end else begin
						// payload byte: pass it on as data
						res.kind      = 1'b0;
						res.data_byte = rx_byte;
						res.last      = 1'b0;
					end
				end
				PH_DCS: begin
					res_valid = 1'b1;
					if (data_sum != 8'h00) begin
						res.status = ST_DCS;
					end else begin
						res.status       = ST_OK;
						res.frame_length = cur.length_seen;
					end
				end
				default: begin
					next_state.phase = PH_IDLE;
				end
			endcase

			// any status closes the window
			if (res_valid && res.kind)
				next_state.phase = PH_IDLE;
		end
	end

endmodule

// File: rtl/nfc_frame_deframer.sv
// ----------------------------------------------------------------------------
// nfc_frame_deframer
// Host-side deframer for one read window of a start code / LEN / LCS /
// payload / DCS frame, one received byte per transaction.
// ----------------------------------------------------------------------------
// Each byte is taken into an input register, parsed combinationally and its
// result, if any, placed in an output register, so a byte is accepted in
// every cycle while the output side keeps up. A byte with start_req opens a
// window of min(window_len, MAX_FRAME_LEN) + 7 bytes and is itself parsed as
// the first byte. Payload bytes come out with kind 0, except one on the last
// position of the window; the window closes with one status result (kind 1,
// last 1). Bytes outside a window give no result, and a new start_req drops
// an open window without a status.
module nfc_frame_deframer #(
	parameter int MAX_FRAME_LEN = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       start_req,
	input  logic [7:0] window_len,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] data_byte,
	output logic [2:0] status,
	output logic [7:0] frame_length,
	output logic       last
);
	import nfcd_pkg::*;

	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         start_req_s1;
	logic [7:0]   window_len_s1;
	parse_state_t state_q;
	parse_state_t next_state;
	logic         res_valid;
	result_t      res;
	logic         out_valid_q;
	result_t      res_q;
	logic         out_free;
	logic         go_s1;

	nfcd_parser #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_parser (
		.state     (state_q),
		.rx_byte   (rx_byte_s1),
		.start_req (start_req_s1),
		.window_len(window_len_s1),
		.next_state(next_state),
		.res_valid (res_valid),
		.res       (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign go_s1    = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register: hold while the parsed byte cannot advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1    <= rx_byte;
			start_req_s1  <= start_req;
			window_len_s1 <= window_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, bytes_left: '0, payload_left: '0,
			             length_seen: '0, running_sum: '0};
		end else if (go_s1) begin
			state_q <= next_state;
		end
	end

	// output register: load a new result or drop the one taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res_valid)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign data_byte    = res_q.data_byte;
	assign status       = res_q.status;
	assign frame_length = res_q.frame_length;
	assign last         = res_q.last;

endmodule

// File: test/nfc_deframe_checker.sv
// ----------------------------------------------------------------------------
// nfc_deframe_checker
// Watches both channels of the frame deframer, predicts the data and status
// results of every accepted byte and compares them in order as they leave.
// ----------------------------------------------------------------------------
module nfc_deframe_checker #(
	parameter int MAX_FRAME_LEN = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       start_req,
	input  logic [7:0] window_len,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	input  logic [2:0] status,
	input  logic [7:0] frame_length,
	input  logic       last,
	output int         fails,
	output int         pending
);
	import nfcd_pkg::*;

	phase_t     ph;
	logic [8:0] window_left;
	logic [7:0] payload_cnt;
	logic [7:0] len_seen;
	logic [7:0] data_sum;

	result_t results_due[$];

	function automatic bit close_window(input status_t st, output result_t r);
		r = '0;
		r.kind = 1'b1;
		r.status = st;
		r.frame_length = (st == ST_OK) ? len_seen : 8'd0;
		r.last = 1'b1;
		ph = PH_IDLE;
		return 1'b1;
	endfunction

	// returns 1 when the byte produces a data or status result
	function automatic bit deframe_byte(input logic [7:0] b, input logic s,
			input logic [7:0] wl, output result_t r);
		logic [8:0] span;
		logic [7:0] chk;
		bit         fin;
		r = '0;
		if (s) begin
			span = {1'b0, wl};
			if (span > 9'(MAX_FRAME_LEN))
				span = 9'(MAX_FRAME_LEN);
			ph = PH_PRE;
			window_left = span + FRAME_EXTRA;
			payload_cnt = 8'd0;
			len_seen = 8'd0;
			data_sum = 8'd0;
		end
		if (ph == PH_IDLE)
			return 1'b0;
		fin = (window_left <= 9'd1);
		if (window_left != 9'd0)
			window_left = window_left - 9'd1;
		case (ph)
			PH_PRE: begin
				if (b == BYTE_ZERO) begin
					if (fin)
						return close_window(ST_START, r);
					return 1'b0;
				end
				if (b != START_CODE)
					return close_window(ST_START, r);
				ph = PH_LEN;
			end
			PH_LEN: begin
				len_seen = b;
				ph = PH_LCS;
			end
			PH_LCS: begin
				chk = len_seen + b;
				if (chk != 8'd0)
					return close_window(ST_LCS, r);
				data_sum = 8'd0;
				payload_cnt = len_seen;
				ph = (len_seen != 8'd0) ? PH_DATA : PH_DCS;
			end
			PH_DATA: begin
				data_sum = data_sum + b;
				payload_cnt = payload_cnt - 8'd1;
				if (payload_cnt == 8'd0)
					ph = PH_DCS;
				// a payload byte on the final position of the window is dropped
				if (fin)
					return close_window(ST_EXHAUST, r);
				r.data_byte = b;
				return 1'b1;
			end
			PH_DCS: begin
				chk = data_sum + b;
				if (chk != 8'd0)
					return close_window(ST_DCS, r);
				return close_window(ST_OK, r);
			end
			default: begin
				ph = PH_IDLE;
				return 1'b0;
			end
		endcase
		if (fin)
			return close_window(ST_EXHAUST, r);
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : watch
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			ph = PH_IDLE;
			window_left = 9'd0;
			payload_cnt = 8'd0;
			len_seen = 8'd0;
			data_sum = 8'd0;
			results_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$display({"%0t: unexpected result, expected none, ",
						"actual kind %0b data %0h status %0d length %0h last %0b"},
						$time, kind, data_byte, status, frame_length, last);
					fails++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", {7'd0, want.kind}, {7'd0, kind});
					check_field("data_byte", want.data_byte, data_byte);
					check_field("status", {5'd0, want.status}, {5'd0, status});
					check_field("frame_length", want.frame_length, frame_length);
					check_field("last", {7'd0, want.last}, {7'd0, last});
				end
			end
			if (in_valid && !in_stall) begin
				if (deframe_byte(rx_byte, start_req, window_len, fresh))
					results_due.push_back(fresh);
			end
		end
		pending = results_due.size();
	end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives read windows into the frame deframer: directed frames for the corner
// cases, then random frames with flaws, restarts and noise, under random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

	import nfcd_pkg::*;

	localparam int ITEM_TARGET = 1450;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {
		FLAW_NONE,
		FLAW_START,
		FLAW_LCS,
		FLAW_DCS
	} flaw_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       start_req;
	logic [7:0] window_len;
	logic       out_valid;
	logic       out_stall;
	logic       kind;
	logic [7:0] data_byte;
	logic [2:0] status;
	logic [7:0] frame_length;
	logic       last;

	int fails;
	int pending;
	int sent = 0;
	int cycle_count = 0;
	int gap_odds = 0;
	int stall_odds = 0;
	bit long_hold_req = 0;
	bit hold_done = 0;

	nfc_frame_deframer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.start_req    (start_req),
		.window_len   (window_len),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.status       (status),
		.frame_length (frame_length),
		.last         (last)
	);

	nfc_deframe_checker check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.start_req    (start_req),
		.window_len   (window_len),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.status       (status),
		.frame_length (frame_length),
		.last         (last),
		.fails        (fails),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one input transaction, optionally after an idle burst
	task automatic put_byte(input logic [7:0] b, input logic s, input logic [7:0] wl);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		start_req <= s;
		window_len <= wl;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [7:0] payload_byte();
		case ($urandom_range(0, 7))
			0: return BYTE_ZERO;
			1: return START_CODE;
			default: return 8'($urandom);
		endcase
	endfunction

	// build one frame, send it (or its first cut bytes) as a read window
	task automatic send_window(input int wl, input int zeros, input int len,
			input flaw_t flaw, input int cut, input int tail);
		logic [7:0] frame[$];
		logic [7:0] len8;
		logic [7:0] chk;
		logic [7:0] sum;
		logic [7:0] p;
		int         total;
		len8 = 8'(len);
		sum = 8'd0;
		repeat (zeros) frame.push_back(BYTE_ZERO);
		frame.push_back((flaw == FLAW_START) ?
			8'($urandom_range(1, 254)) : START_CODE);
		frame.push_back(len8);
		chk = ~len8 + 8'd1;
		if (flaw == FLAW_LCS)
			chk = chk ^ 8'($urandom_range(1, 255));
		frame.push_back(chk);
		repeat (len) begin
			p = payload_byte();
			sum = sum + p;
			frame.push_back(p);
		end
		chk = ~sum + 8'd1;
		if (flaw == FLAW_DCS)
			chk = chk ^ 8'($urandom_range(1, 255));
		frame.push_back(chk);
		repeat (tail) frame.push_back(8'($urandom));
		total = frame.size();
		if (cut >= 0 && cut < total)
			total = cut;
		for (int i = 0; i < total; i++)
			put_byte(frame[i], i == 0, (i == 0) ? 8'(wl) : 8'($urandom));
	endtask

	initial begin : stimulus
		int len;
		int wl;
		int zeros;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		start_req = 1'b0;
		window_len = 8'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_odds = 3;
		stall_odds = 3;
		// byte outside any window
		put_byte(8'h5C, 1'b0, 8'hFF);
		// empty payload
		send_window(0, 0, 0, FLAW_NONE, -1, 0);
		// window of zeros only
		send_window(0, 7, 0, FLAW_NONE, 7, 0);
		// abort a window by a restart whose first byte is a wrong start code
		send_window(255, 0, 4, FLAW_NONE, 1, 0);
		send_window(255, 0, 0, FLAW_START, 1, 0);
		send_window(3, 0, 3, FLAW_LCS, 3, 0);
		send_window(1, 0, 1, FLAW_DCS, -1, 0);
		// window ends on a payload byte
		send_window(0, 0, 5, FLAW_NONE, 7, 0);

		// hold the output long enough for the input side to back up
		gap_odds = 0;
		stall_odds = 0;
		long_hold_req = 1'b1;
		send_window(40, 0, 40, FLAW_NONE, -1, 0);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);

		while (sent < ITEM_TARGET) begin
			if (sent >= ITEM_TARGET - 200) begin
				gap_odds = 0;
				stall_odds = 0;
			end else begin
				gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
				stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
			end
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 4))
					put_byte(8'($urandom), ($urandom_range(0, 7) == 0), 8'($urandom));
			end else begin
				len = ($urandom_range(0, 59) == 0) ?
					$urandom_range(100, 255) : $urandom_range(0, 12);
				case ($urandom_range(0, 3))
					0, 1: wl = len;
					2: begin
						wl = len + $urandom_range(0, 8);
						if (wl > 255)
							wl = 255;
					end
					default: wl = $urandom_range(0, 255);
				endcase
				zeros = $urandom_range(0, 3);
				if (wl <= 16 && $urandom_range(0, 19) == 0)
					zeros = wl + 7;
				pick = $urandom_range(0, 99);
				if (pick < 70)
					send_window(wl, zeros, len, FLAW_NONE, -1, $urandom_range(0, 2));
				else if (pick < 77)
					send_window(wl, zeros, len, FLAW_START, -1, $urandom_range(0, 2));
				else if (pick < 84)
					send_window(wl, zeros, len, FLAW_LCS, -1, $urandom_range(0, 2));
				else if (pick < 92)
					send_window(wl, zeros, len, FLAW_DCS, -1, $urandom_range(0, 2));
				else
					send_window(wl, zeros, len, FLAW_NONE,
						$urandom_range(1, zeros + len + 3), 0);
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
